// ===== hw/rtl/brg_pkg.sv =====
// ----------------------------------------------------------------------------
// brg_pkg
// Shared types, codes and defaults of the breakpoint ramp generator.
// ----------------------------------------------------------------------------
`default_nettype none

package brg_pkg;

    localparam int MAX_SEGMENTS_DEF     = 64;
    localparam int DEFAULT_GRAIN_MS_DEF = 20;
    localparam int FRAC_BITS_DEF        = 16;

    localparam int VAL_W = 32;
    localparam int DUR_W = 31;
    localparam int OP_W  = 4;
    localparam int CIX_W = 2;

    localparam logic [OP_W-1:0] OP_TICK   = 4'd0;
    localparam logic [OP_W-1:0] OP_RTIME  = 4'd1;
    localparam logic [OP_W-1:0] OP_GRAIN  = 4'd2;
    localparam logic [OP_W-1:0] OP_TARGET = 4'd3;
    localparam logic [OP_W-1:0] OP_PAIR   = 4'd4;
    localparam logic [OP_W-1:0] OP_STOP   = 4'd5;
    localparam logic [OP_W-1:0] OP_PAUSE  = 4'd6;
    localparam logic [OP_W-1:0] OP_RESUME = 4'd7;
    localparam logic [OP_W-1:0] OP_SET    = 4'd8;

    localparam logic [CIX_W-1:0] CFG_FLOAT   = 2'd0;
    localparam logic [CIX_W-1:0] CFG_INITIAL = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK_CHK,
        ST_MOD_WAIT,
        ST_RUN,
        ST_MUL2,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_BEG_RD,
        ST_BEG_LD,
        ST_BEG_MUL,
        ST_BEG_FIN,
        ST_EMIT
    } brg_state_t;

    typedef struct packed {
        logic latch;
        logic set_pending;
        logic set_grain;
        logic halt;
        logic push;
        logic push_pending;
        logic start;
        logic pause;
        logic resume;
        logic set_now;
        logic tick_inc;
        logic div_start;
        logic div_mod;
        logic mul1;
        logic mul2;
        logic value_load;
        logic value_goal;
        logic beg_empty;
        logic mark_arrived;
        logic beg_read;
        logic beg_load;
        logic beg_mul;
        logic beg_fin;
        logic emit;
        logic run_end;
    } brg_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            last;
        logic            running;
        logic            run_active;
        logic            paused_run;
        logic            len_zero;
        logic            done;
        logic            q_empty;
        logic            div_done;
        logic            rem_zero;
        logic            slot_free;
    } brg_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/breakpoint_ramp_generator.sv =====
// ----------------------------------------------------------------------------
// breakpoint_ramp_generator
// Breakpoint ramp generator over a queue of target/time segments.
// A segment start also reads and loads the next queued segment. A running tick
// tests the grain boundary (serial 32-step divider), then divides again for an
// interpolated value; a tick that ends a segment skips both divisions.
// One item at a time. Reset clears control state; queue memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module breakpoint_ramp_generator #(
    parameter int MAX_SEGMENTS     = brg_pkg::MAX_SEGMENTS_DEF,
    parameter int DEFAULT_GRAIN_MS = brg_pkg::DEFAULT_GRAIN_MS_DEF,
    parameter int FRAC_BITS        = brg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [brg_pkg::CIX_W-1:0] cfg_index,
    input  wire logic [31:0]               cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic [brg_pkg::OP_W-1:0]  opcode,
    input  wire logic signed [31:0]        level,
    input  wire logic [30:0]               duration_ms,
    input  wire logic                      final_pair,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic signed [31:0]             out_value,
    output logic                           is_fraction,
    output logic                           arrived,
    output logic                           run_end
);
    import brg_pkg::*;

    brg_cmd_t  cmd;
    brg_stat_t stat;

    assign cfg_ready = 1'b1;

    brg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    brg_dp #(
        .MAX_SEGMENTS     (MAX_SEGMENTS),
        .DEFAULT_GRAIN_MS (DEFAULT_GRAIN_MS),
        .FRAC_BITS        (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .level       (level),
        .duration_ms (duration_ms),
        .final_pair  (final_pair),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_value   (out_value),
        .is_fraction (is_fraction),
        .arrived     (arrived),
        .run_end     (run_end)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/brg_div.sv =====
// ----------------------------------------------------------------------------
// brg_div
// Radix-2 restoring divider, one quotient bit per cycle, 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module brg_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [30:0] rem_init,
    input  wire logic [31:0] dividend,
    input  wire logic [30:0] divisor,
    output logic             done,
    output logic [31:0]      quotient,
    output logic [30:0]      remainder
);
    logic [30:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [30:0] div_reg;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        take;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        diff      = trial - {1'b0, div_reg};
        take      = trial >= {1'b0, div_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = rem_init;
            quo_next  = dividend;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = take ? diff[30:0] : trial[30:0];
            quo_next = {quo_reg[30:0], take};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/brg_ctrl.sv =====
// ----------------------------------------------------------------------------
// brg_ctrl
// Sequencer of the ramp generator: decodes items, steps segments and results.
// ----------------------------------------------------------------------------
`default_nettype none

module brg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire brg_pkg::brg_stat_t stat,
    output brg_pkg::brg_cmd_t      cmd
);
    import brg_pkg::*;

    brg_state_t state_reg, state_next;
    logic       from_run_reg, from_run_next;
    logic       again_reg, again_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            from_run_reg <= 1'b0;
            again_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            from_run_reg <= from_run_next;
            again_reg    <= again_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        from_run_next = from_run_reg;
        again_next    = again_reg;
        cmd           = '0;
        in_stall      = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                case (stat.op)
                    OP_TICK:
                    begin
                        if (stat.run_active)
                        begin
                            if (stat.len_zero)
                            begin
                                state_next = ST_RUN;
                            end
                            else
                            begin
                                cmd.tick_inc = 1'b1;
                                state_next   = ST_TICK_CHK;
                            end
                        end
                    end
                    OP_RTIME:  cmd.set_pending = 1'b1;
                    OP_GRAIN:  cmd.set_grain = 1'b1;
                    OP_TARGET:
                    begin
                        cmd.halt         = 1'b1;
                        cmd.push         = 1'b1;
                        cmd.push_pending = 1'b1;
                        cmd.start        = 1'b1;
                        from_run_next    = 1'b0;
                        state_next       = ST_BEG_RD;
                    end
                    OP_PAIR:
                    begin
                        cmd.halt = stat.running;
                        cmd.push = 1'b1;
                        if (stat.last)
                        begin
                            cmd.start     = 1'b1;
                            from_run_next = 1'b0;
                            state_next    = ST_BEG_RD;
                        end
                    end
                    OP_STOP:   cmd.halt = 1'b1;
                    OP_PAUSE:  cmd.pause = stat.run_active;
                    OP_RESUME:
                    begin
                        if (stat.paused_run)
                        begin
                            cmd.resume = 1'b1;
                            if (stat.len_zero)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                    end
                    OP_SET:
                    begin
                        cmd.halt    = 1'b1;
                        cmd.set_now = 1'b1;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_TICK_CHK:
            begin
                if (stat.done)
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_mod   = 1'b1;
                    state_next    = ST_MOD_WAIT;
                end
            end
            ST_MOD_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = stat.rem_zero ? ST_RUN : ST_IDLE;
                end
            end
            ST_RUN:
            begin
                if (stat.done)
                begin
                    cmd.value_load = 1'b1;
                    cmd.value_goal = 1'b1;
                    from_run_next  = 1'b1;
                    state_next     = ST_BEG_RD;
                end
                else
                begin
                    cmd.mul1   = 1'b1;
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.value_load = 1'b1;
                    again_next     = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_BEG_RD:
            begin
                if (stat.q_empty)
                begin
                    cmd.beg_empty = 1'b1;
                    if (from_run_reg)
                    begin
                        cmd.mark_arrived = 1'b1;
                        again_next       = 1'b0;
                        state_next       = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.beg_read = 1'b1;
                    state_next   = ST_BEG_LD;
                end
            end
            ST_BEG_LD:
            begin
                cmd.beg_load = 1'b1;
                state_next   = ST_BEG_MUL;
            end
            ST_BEG_MUL:
            begin
                cmd.beg_mul = 1'b1;
                state_next  = ST_BEG_FIN;
            end
            ST_BEG_FIN:
            begin
                cmd.beg_fin = 1'b1;
                if (from_run_reg)
                begin
                    again_next = stat.len_zero;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = stat.len_zero ? ST_RUN : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (stat.slot_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.run_end = !again_reg;
                    state_next  = again_reg ? ST_RUN : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/brg_dp.sv =====
// ----------------------------------------------------------------------------
// brg_dp
// Datapath: ramp state, segment queue, interpolation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module brg_dp #(
    parameter int MAX_SEGMENTS     = brg_pkg::MAX_SEGMENTS_DEF,
    parameter int DEFAULT_GRAIN_MS = brg_pkg::DEFAULT_GRAIN_MS_DEF,
    parameter int FRAC_BITS        = brg_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire brg_pkg::brg_cmd_t           cmd,
    output brg_pkg::brg_stat_t               stat,
    input  wire logic                        cfg_valid,
    input  wire logic [brg_pkg::CIX_W-1:0]   cfg_index,
    input  wire logic [31:0]                 cfg_data,
    input  wire logic [brg_pkg::OP_W-1:0]    opcode,
    input  wire logic signed [31:0]          level,
    input  wire logic [30:0]                 duration_ms,
    input  wire logic                        final_pair,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic signed [31:0]               out_value,
    output logic                             is_fraction,
    output logic                             arrived,
    output logic                             run_end
);
    import brg_pkg::*;

    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int D5_W  = FRAC_BITS + 3;
    localparam int FP_W  = FRAC_BITS + 34;
    localparam logic [32:0]      ONE_33  = 33'(1) << FRAC_BITS;
    localparam logic [D5_W-1:0]  TWO_D5  = D5_W'(2) << FRAC_BITS;
    localparam logic [31:0]      FMASK   = 32'((64'(1) << FRAC_BITS) - 64'(1));

    // latched item
    logic [OP_W-1:0] op_reg;
    logic [31:0]     lvl_reg;
    logic [30:0]     dur_reg;
    logic            last_reg;

    // ramp state
    logic            float_reg;
    logic [31:0]     now_reg, start_reg, goal_reg;
    logic [30:0]     len_reg, elapsed_reg, grain_reg, pending_reg;
    logic [CNT_W-1:0] count_reg, next_reg;
    logic            running_reg, paused_reg, frac_reg;

    // working registers
    logic [62:0]     prod_reg;
    logic [31:0]     dist_reg;
    logic [FP_W-1:0] fprod_reg;
    logic [31:0]     value_reg;
    logic            vfrac_reg, varr_reg;
    logic [31:0]     rd_lvl_reg;
    logic [30:0]     rd_time_reg;

    // output register
    logic            out_valid_reg;
    logic [31:0]     out_value_reg;
    logic            out_frac_reg, out_arr_reg, out_end_reg;

    logic [31:0]     qlevel [MAX_SEGMENTS];
    logic [30:0]     qtime  [MAX_SEGMENTS];

    logic [30:0]     grain_now;
    logic [32:0]     diff;
    logic [32:0]     diff_abs;
    logic            neg;
    logic [32:0]     rd_diff;
    logic [32:0]     rd_abs;
    logic [CNT_W-1:0] base;
    logic            push_ok;
    logic [D5_W-1:0] dist5;
    logic [32:0]     qsigned;
    logic [32:0]     calc_sum;
    logic [31:0]     trunc_val;
    logic            div_done;
    logic [31:0]     div_q;
    logic [30:0]     div_r;
    logic [30:0]     div_rem_init;
    logic [31:0]     div_dividend;
    logic [30:0]     div_divisor;
    logic            slot_free;
    logic            frac_auto;

    assign grain_now = (grain_reg != '0) ? grain_reg : DUR_W'(DEFAULT_GRAIN_MS);
    assign diff      = {goal_reg[31], goal_reg} - {start_reg[31], start_reg};
    assign neg       = diff[32];
    assign diff_abs  = neg ? (33'(0) - diff) : diff;
    assign rd_diff   = {rd_lvl_reg[31], rd_lvl_reg} - {now_reg[31], now_reg};
    assign rd_abs    = rd_diff[32] ? (33'(0) - rd_diff) : rd_diff;
    assign base      = cmd.halt ? '0 : count_reg;
    assign push_ok   = base < CNT_W'(MAX_SEGMENTS);
    assign dist5     = {dist_reg[FRAC_BITS:0], 2'b00} + D5_W'(dist_reg[FRAC_BITS:0]);
    assign qsigned   = neg ? (33'(0) - {1'b0, div_q}) : {1'b0, div_q};
    assign calc_sum  = {start_reg[31], start_reg} + qsigned;
    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        if ({1'b0, dist_reg} > ONE_33)
        begin
            frac_auto = 1'b0;
        end
        else if (len_reg == '0)
        begin
            frac_auto = dist5 < TWO_D5;
        end
        else
        begin
            frac_auto = fprod_reg < {2'b00, len_reg, {(FRAC_BITS + 1){1'b0}}};
        end
    end

    always_comb
    begin
        if (cmd.div_mod)
        begin
            div_rem_init = '0;
            div_dividend = {1'b0, elapsed_reg};
            div_divisor  = grain_now;
        end
        else
        begin
            div_rem_init = prod_reg[62:32];
            div_dividend = prod_reg[31:0];
            div_divisor  = len_reg;
        end
    end

    always_comb
    begin
        if (vfrac_reg)
        begin
            trunc_val = value_reg;
        end
        else if (value_reg[31] && ((value_reg & FMASK) != '0))
        begin
            trunc_val = (value_reg & ~FMASK) + (FMASK + 32'd1);
        end
        else
        begin
            trunc_val = value_reg & ~FMASK;
        end
    end

    brg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .rem_init  (div_rem_init),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.push && push_ok)
        begin
            qlevel[base[IDX_W-1:0]] <= lvl_reg;
            qtime[base[IDX_W-1:0]]  <= cmd.push_pending ? pending_reg : dur_reg;
        end
        if (cmd.beg_read)
        begin
            rd_lvl_reg  <= qlevel[next_reg[IDX_W-1:0]];
            rd_time_reg <= qtime[next_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg   <= opcode;
            lvl_reg  <= level;
            dur_reg  <= duration_ms;
            last_reg <= final_pair;
        end
        if (cmd.mul1)
        begin
            prod_reg <= 63'(diff_abs[31:0] * elapsed_reg[15:0]);
        end
        if (cmd.mul2)
        begin
            prod_reg <= prod_reg + (63'(diff_abs[31:0] * elapsed_reg[30:16]) << 16);
        end
        if (cmd.beg_load)
        begin
            dist_reg <= rd_abs[31:0];
        end
        if (cmd.beg_mul)
        begin
            fprod_reg <= FP_W'(dist5 * grain_now);
        end
        if (cmd.value_load)
        begin
            value_reg <= cmd.value_goal ? goal_reg : calc_sum[31:0];
            vfrac_reg <= frac_reg;
        end
        if (cmd.emit)
        begin
            out_value_reg <= trunc_val;
            out_frac_reg  <= vfrac_reg;
            out_arr_reg   <= varr_reg;
            out_end_reg   <= cmd.run_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            float_reg     <= 1'b0;
            now_reg       <= '0;
            start_reg     <= '0;
            goal_reg      <= '0;
            len_reg       <= '0;
            elapsed_reg   <= '0;
            grain_reg     <= DUR_W'(DEFAULT_GRAIN_MS);
            pending_reg   <= '0;
            count_reg     <= '0;
            next_reg      <= '0;
            running_reg   <= 1'b0;
            paused_reg    <= 1'b0;
            frac_reg      <= 1'b0;
            varr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && (cfg_index == CFG_FLOAT))
            begin
                float_reg <= cfg_data[0];
            end
            if (cfg_valid && (cfg_index == CFG_INITIAL))
            begin
                now_reg <= cfg_data;
            end
            if (cmd.set_pending)
            begin
                pending_reg <= dur_reg;
            end
            if (cmd.set_grain)
            begin
                grain_reg <= dur_reg;
            end
            if (cmd.halt)
            begin
                running_reg <= 1'b0;
                paused_reg  <= 1'b0;
                count_reg   <= '0;
                next_reg    <= '0;
                len_reg     <= '0;
                elapsed_reg <= '0;
            end
            if (cmd.push)
            begin
                if (push_ok)
                begin
                    count_reg <= base + CNT_W'(1);
                end
                if (cmd.push_pending)
                begin
                    pending_reg <= '0;
                end
            end
            if (cmd.start)
            begin
                next_reg   <= '0;
                paused_reg <= 1'b0;
            end
            if (cmd.set_now)
            begin
                now_reg <= lvl_reg;
            end
            if (cmd.pause)
            begin
                start_reg   <= now_reg;
                len_reg     <= (elapsed_reg >= len_reg) ? '0 : len_reg - elapsed_reg;
                elapsed_reg <= '0;
                paused_reg  <= 1'b1;
            end
            if (cmd.resume)
            begin
                paused_reg  <= 1'b0;
                elapsed_reg <= '0;
            end
            if (cmd.tick_inc && (elapsed_reg < len_reg))
            begin
                elapsed_reg <= elapsed_reg + DUR_W'(1);
            end
            if (cmd.value_load)
            begin
                now_reg  <= cmd.value_goal ? goal_reg : calc_sum[31:0];
                varr_reg <= 1'b0;
            end
            if (cmd.beg_empty)
            begin
                count_reg   <= '0;
                next_reg    <= '0;
                running_reg <= 1'b0;
                paused_reg  <= 1'b0;
                len_reg     <= '0;
            end
            if (cmd.mark_arrived)
            begin
                varr_reg <= 1'b1;
            end
            if (cmd.beg_load)
            begin
                start_reg   <= now_reg;
                goal_reg    <= rd_lvl_reg;
                len_reg     <= rd_time_reg;
                elapsed_reg <= '0;
                next_reg    <= next_reg + CNT_W'(1);
            end
            if (cmd.beg_fin)
            begin
                frac_reg    <= float_reg || frac_auto;
                running_reg <= 1'b1;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.op         = op_reg;
        stat.last       = last_reg;
        stat.running    = running_reg;
        stat.run_active = running_reg && !paused_reg;
        stat.paused_run = running_reg && paused_reg;
        stat.len_zero   = len_reg == '0;
        stat.done       = (len_reg == '0) || (elapsed_reg >= len_reg);
        stat.q_empty    = (next_reg >= count_reg) || (next_reg >= CNT_W'(MAX_SEGMENTS));
        stat.div_done   = div_done;
        stat.rem_zero   = div_r == '0;
        stat.slot_free  = slot_free;
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = out_value_reg;
    assign is_fraction = out_frac_reg;
    assign arrived     = out_arr_reg;
    assign run_end     = out_end_reg;

endmodule

`default_nettype wire
